// File: sv/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg: shared types and constants for the homogeneous point transform
// Fixed-point widths, item structs and the product bundle between the front
// end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpt_pkg;

  // Fixed-point format of coefficients, coordinates and results
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  // Three products plus the aligned translation term need two guard bits
  localparam int ACC_W     = PROD_W + 2;
  // Width of a column sum after dropping FRAC_BITS fraction bits
  localparam int RED_W     = ACC_W - FRAC_BITS;
  // Numerator bits that enter the divider from below
  localparam int SHIFT_W   = DATA_W - FRAC_BITS;
  localparam int DIV_STEPS = DATA_W;
  localparam int MAT_N     = 16;
  localparam int IDX_W     = 4;

  localparam logic [DATA_W-1:0] FIX_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_POINT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  entry_index;
    logic [DATA_W-1:0] entry_value;
    logic [DATA_W-1:0] in_x;
    logic [DATA_W-1:0] in_y;
    logic [DATA_W-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_x;
    logic [DATA_W-1:0] out_y;
    logic [DATA_W-1:0] out_z;
    logic              w_was_zero;
    logic              saturated;
  } out_item_t;

  // Per column: three row products and the translation coefficient
  typedef struct packed {
    logic [3:0][2:0][PROD_W-1:0] prod;
    logic [3:0][DATA_W-1:0]      trans;
  } prod_t;

  // Exact signed product of two coefficients
  function automatic logic [PROD_W-1:0] smul(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b);
    logic signed [PROD_W-1:0] ea;
    logic signed [PROD_W-1:0] eb;
    ea = PROD_W'($signed(a));
    eb = PROD_W'($signed(b));
    return ea * eb;
  endfunction

endpackage

// File: sv/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front: item decode, matrix store and row products
// Writes matrix entries and forms the twelve products of a point with the
// matrix as it stands when the point is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  hpt_pkg::in_item_t in_item_i,
  output logic              push_o,
  output hpt_pkg::prod_t    prod_o
);
  import hpt_pkg::*;

  logic [DATA_W-1:0] mat_q [MAT_N];
  logic [2:0][DATA_W-1:0] pt;

  // Hold the matrix; reset to identity, write on load items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAT_N; i++) begin
        mat_q[i] <= ((i / 4) == (i % 4)) ? FIX_ONE : '0;
      end
    end else if (accept_i && in_item_i.kind == KIND_WRITE) begin
      mat_q[in_item_i.entry_index] <= in_item_i.entry_value;
    end
  end

  assign pt     = {in_item_i.in_z, in_item_i.in_y, in_item_i.in_x};
  assign push_o = accept_i && in_item_i.kind == KIND_POINT;

  // Multiply the point by each column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod_o.prod[c][r] = smul(pt[r], mat_q[r*4+c]);
      end
      prod_o.trans[c] = mat_q[12+c];
    end
  end

endmodule

// File: sv/hpt_queue.sv
// ----------------------------------------------------------------------------
// hpt_queue: two-entry queue between front end and back end
// Lets the front keep accepting while the back end stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hpt_pkg::prod_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output hpt_pkg::prod_t data_o,
  output logic           empty_o
);
  import hpt_pkg::*;

  prod_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: sv/hpt_back.sv
// ----------------------------------------------------------------------------
// hpt_back: column sums, perspective divide and saturation
// Pipeline of sum, reduce, magnitude, divider setup, one quotient bit per
// stage, and an output register. All stages advance together.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_data_i,
  input  hpt_pkg::prod_t     q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic               out_pop_i,
  output logic               out_empty_o,
  output hpt_pkg::out_item_t out_item_o
);
  import hpt_pkg::*;

  typedef struct packed {
    logic [2:0][RED_W-1:0]  rem;
    logic [2:0][DATA_W-1:0] qn;
    logic [RED_W-1:0]       d;
    logic [2:0]             neg;
    logic [2:0]             big;
    logic [2:0]             affsat;
    logic [2:0][DATA_W-1:0] aff;
    logic                   use_div;
    logic                   wflag;
  } div_t;

  logic div_mode_q;
  logic en;

  logic                    s1_vld_q, s2_vld_q, s3_vld_q;
  logic signed [ACC_W-1:0] s1_sa_q [4];
  logic signed [ACC_W-1:0] s1_sb_q [4];
  logic [RED_W-1:0]        s2_red_q [4];
  div_t                    s3_q, s3_d;
  logic [DIV_STEPS:0]      dv_vld_q;
  div_t                    dv_q [DIV_STEPS+1];
  div_t                    dv_d [DIV_STEPS+1];
  logic                    out_vld_q;
  out_item_t               out_q, out_d;

  assign en          = !out_vld_q || out_pop_i;
  assign q_pop_o     = en && !q_empty_i;
  assign out_empty_o = !out_vld_q;
  assign out_item_o  = out_q;

  // Hold the divide mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      div_mode_q <= cfg_data_i;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= !q_empty_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      dv_vld_q  <= {dv_vld_q[DIV_STEPS-1:0], s3_vld_q};
      out_vld_q <= dv_vld_q[DIV_STEPS];
    end
  end

  // Magnitudes, signs, zero w and the undivided saturated result
  always_comb begin
    logic [RED_W-1:0] r;
    logic [RED_W-1:0] w;
    logic             fits;
    s3_d = '0;
    w    = s2_red_q[3];
    for (int c = 0; c < 3; c++) begin
      r    = s2_red_q[c];
      fits = (&r[RED_W-1:DATA_W-1]) || !(|r[RED_W-1:DATA_W-1]);
      s3_d.aff[c]    = fits ? r[DATA_W-1:0] : (r[RED_W-1] ? SAT_MIN : SAT_MAX);
      s3_d.affsat[c] = !fits;
      s3_d.neg[c]    = r[RED_W-1] ^ w[RED_W-1];
      // numerator magnitude rides in the remainder slot until setup
      s3_d.rem[c]    = r[RED_W-1] ? (~r + RED_W'(1)) : r;
    end
    s3_d.d       = w[RED_W-1] ? (~w + RED_W'(1)) : w;
    s3_d.use_div = div_mode_q && (w != '0);
    s3_d.wflag   = div_mode_q && (w == '0);
  end

  // Divider setup: overflow check and initial remainder
  always_comb begin
    logic [RED_W-1:0] n;
    dv_d[0] = s3_q;
    for (int c = 0; c < 3; c++) begin
      n = s3_q.rem[c];
      dv_d[0].big[c] = {{SHIFT_W{1'b0}}, n} >= {s3_q.d, {SHIFT_W{1'b0}}};
      dv_d[0].rem[c] = RED_W'(n >> SHIFT_W);
      dv_d[0].qn[c]  = {n[SHIFT_W-1:0], {FRAC_BITS{1'b0}}};
    end
  end

  // One quotient bit per stage for each coordinate
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_comb begin
      logic [RED_W:0] trial;
      logic           ge;
      dv_d[k+1] = dv_q[k];
      for (int c = 0; c < 3; c++) begin
        trial = {dv_q[k].rem[c], dv_q[k].qn[c][DATA_W-1]} - {1'b0, dv_q[k].d};
        ge    = !trial[RED_W];
        dv_d[k+1].rem[c] = ge ? trial[RED_W-1:0]
                              : {dv_q[k].rem[c][RED_W-2:0], dv_q[k].qn[c][DATA_W-1]};
        dv_d[k+1].qn[c]  = {dv_q[k].qn[c][DATA_W-2:0], ge};
      end
    end
  end

  // Pick quotient or undivided value, then saturate
  always_comb begin
    div_t                   f;
    logic [2:0][DATA_W-1:0] res;
    logic [2:0]             sat;
    logic [DATA_W-1:0]      q;
    f = dv_q[DIV_STEPS];
    for (int c = 0; c < 3; c++) begin
      q = f.qn[c];
      if (!f.use_div) begin
        res[c] = f.aff[c];
        sat[c] = f.affsat[c];
      end else if (f.neg[c]) begin
        sat[c] = f.big[c] || (q > SAT_MIN);
        res[c] = sat[c] ? SAT_MIN : (~q + DATA_W'(1));
      end else begin
        sat[c] = f.big[c] || q[DATA_W-1];
        res[c] = sat[c] ? SAT_MAX : q;
      end
    end
    out_d.out_x      = res[0];
    out_d.out_y      = res[1];
    out_d.out_z      = res[2];
    out_d.w_was_zero = f.wflag;
    out_d.saturated  = |sat;
  end

  // Move payload through all stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s1_sa_q[c] <= ACC_W'($signed(q_data_i.prod[c][0]))
                    + ACC_W'($signed(q_data_i.prod[c][1]));
        s1_sb_q[c] <= ACC_W'($signed(q_data_i.prod[c][2]))
                    + (ACC_W'($signed(q_data_i.trans[c])) <<< FRAC_BITS);
        s2_red_q[c] <= RED_W'((s1_sa_q[c] + s1_sb_q[c]) >>> FRAC_BITS);
      end
      s3_q <= s3_d;
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_q[k] <= dv_d[k];
      end
      out_q <= out_d;
    end
  end

endmodule

// File: sv/homogeneous_point_transform_top.sv
// Results: a point passes the queue, then the sum, reduce, magnitude, setup,
// quotient and output registers to the result ports; matrix writes give no result.
// Throughput: one item per cycle while the queue is not full; the 32-stage quotient pipeline sets depth.
// Reset: matrix returns to identity, divide mode to 1, the queue to empty;
// items can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
// homogeneous_point_transform_top: 4x4 point transform with perspective divide
// Front end decodes items and multiplies, a short queue decouples it from the
// back end that sums, divides and saturates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module homogeneous_point_transform_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hpt_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output hpt_pkg::out_item_t out_item_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data_i
);
  import hpt_pkg::*;

  logic  accept, q_push, q_pop, q_empty;
  prod_t q_wdata, q_rdata;

  assign accept    = push && !full;
  assign cfg_ready = 1'b1;

  hpt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .push_o    (q_push),
    .prod_o    (q_wdata)
  );

  hpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  hpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid && cfg_ready),
    .cfg_data_i  (cfg_data_i),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_item_o  (out_item_o)
  );

endmodule

// File: sv/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker: port-level checks for the point transform
// Tracks points in flight and checks result hold, extra results and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input hpt_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input hpt_pkg::out_item_t out_item_o
);
  import hpt_pkg::*;

  logic [7:0] pend_q;
  logic       in_pt, out_tk;

  assign in_pt  = push && !full && in_item_i.kind == KIND_POINT;
  assign out_tk = pop && !empty;

  // Count points accepted but not yet taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_pt) - 8'(out_tk);
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed while waiting");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != 8'd0))
    else $error("result without a pending point");

  a_sat_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.saturated) |->
      (out_item_o.out_x == SAT_MAX || out_item_o.out_x == SAT_MIN ||
       out_item_o.out_y == SAT_MAX || out_item_o.out_y == SAT_MIN ||
       out_item_o.out_z == SAT_MAX || out_item_o.out_z == SAT_MIN))
    else $error("saturation flag without a clipped value");

endmodule

bind homogeneous_point_transform_top hpt_checker u_hpt_checker (.*);
